/* rtl/svarr_pkg.sv */
// Shared types, codes and constants of the snapshot versioned array.
package svarr_pkg;

	localparam int OPCODE_W = 2;
	localparam int INDEX_W  = 10;
	localparam int VALUE_W  = 30;
	localparam int SNAP_W   = 16;
	localparam int STATUS_W = 2;

	localparam int LENGTH_DEF     = 1024;
	localparam int HISTORY_DEF    = 16;
	localparam int VALUE_BITS_DEF = 30;
	localparam int SNAP_BITS_DEF  = 16;

	typedef enum logic [OPCODE_W-1:0] {
		OP_SET  = 2'd0,
		OP_SNAP = 2'd1,
		OP_GET  = 2'd2,
		OP_NOP  = 2'd3
	} op_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK        = 2'd0,
		ST_FULL      = 2'd1,
		ST_EXHAUSTED = 2'd2,
		ST_NOT_TAKEN = 2'd3
	} status_t;

	typedef struct packed {
		logic wr_en;
		logic full;
	} row_flags_t;

endpackage

/* rtl/svarr_ram.sv */
// Generic simple dual-port RAM with one write port and a registered read port.
module svarr_ram #(
	parameter int W = 8,
	parameter int D = 16,
	localparam int AW = (D > 1) ? $clog2(D) : 1
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [W-1:0]  wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr,
	output logic [W-1:0]  rdata
);

	logic [W-1:0] mem [D];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

/* rtl/svarr_row_unit.sv */
// Row logic: epoch compare, set update and snapshot search over one history row.
module svarr_row_unit #(
	parameter int HISTORY    = svarr_pkg::HISTORY_DEF,
	parameter int VALUE_BITS = svarr_pkg::VALUE_BITS_DEF,
	parameter int SNAP_BITS  = svarr_pkg::SNAP_BITS_DEF,
	localparam int EW  = SNAP_BITS + 1,
	localparam int ENW = EW + VALUE_BITS,
	localparam int RW  = HISTORY * ENW,
	localparam int FW  = $clog2(HISTORY + 1),
	localparam int QW  = (EW > svarr_pkg::SNAP_W) ? EW : svarr_pkg::SNAP_W
) (
	input  logic [RW-1:0]                  row,
	input  logic [FW-1:0]                  fill,
	input  logic [EW-1:0]                  epoch,
	input  logic [VALUE_BITS-1:0]          value,
	input  logic [svarr_pkg::SNAP_W-1:0]   query,
	output logic [RW-1:0]                  new_row,
	output logic [FW-1:0]                  new_fill,
	output logic [VALUE_BITS-1:0]          get_value,
	output svarr_pkg::row_flags_t          flags
);

	logic [EW-1:0]         ep [HISTORY];
	logic [VALUE_BITS-1:0] vl [HISTORY];
	logic [EW-1:0]         last_ep;
	logic                  same_ep;
	logic                  full;
	logic [FW-1:0]         slot;

	always_comb begin
		last_ep = '0;
		for (int j = 0; j < HISTORY; j++) begin
			ep[j] = row[j*ENW+VALUE_BITS +: EW];
			vl[j] = row[j*ENW +: VALUE_BITS];
			if (FW'(j) + FW'(1) == fill) begin
				last_ep = ep[j];
			end
		end
	end

	assign same_ep = (fill != '0) && (last_ep == epoch);
	assign full    = 32'(fill) >= HISTORY;
	assign slot    = same_ep ? fill - FW'(1) : fill;

	always_comb begin
		flags.wr_en = same_ep || !full;
		flags.full  = !same_ep && full;
		new_fill    = same_ep ? fill : fill + FW'(1);
		new_row     = row;
		for (int j = 0; j < HISTORY; j++) begin
			if (FW'(j) == slot) begin
				new_row[j*ENW +: ENW] = {epoch, value};
			end
		end
	end

	always_comb begin
		get_value = '0;
		for (int j = 0; j < HISTORY; j++) begin
			if ((FW'(j) < fill) && (QW'(ep[j]) <= QW'(query))) begin
				get_value = vl[j];
			end
		end
	end

endmodule

/* rtl/snapshot_versioned_array.sv */
// Top level of the snapshot versioned array: command port, row memories and result register.
//
// An item is taken at a rising edge where start is high and busy is low. The
// opcode selects a set (write elem_index), a snap (close the current epoch) or
// a get (value of elem_index as of snapshot query_snap); the fourth code does
// nothing. Every item yields exactly one result: done is high for one cycle
// while read_value, snap_number and status hold it.
// Each index keeps a row of HISTORY entries in one wide memory and its fill
// count in a second memory. The edge that takes the item reads both memories;
// the next cycle compares all epochs of the row in parallel, writes the row
// back and registers the result. The take sets valid_s1, the row stage then sets
// done_q, and the result is taken at the edge that ends the done pulse. busy stays
// high for one cycle after each item, so the block takes no new item before the
// last one has written its row back; the read and write-back on the row memory set that limit.
// After reset the fill counts are cleared in a pass over all LENGTH indices, one
// index a cycle, while busy is high. The snapshot counter resets to zero.
// The receiver cannot stall: each result is shown once and must be taken.
module snapshot_versioned_array #(
	parameter int LENGTH     = svarr_pkg::LENGTH_DEF,
	parameter int HISTORY    = svarr_pkg::HISTORY_DEF,
	parameter int VALUE_BITS = svarr_pkg::VALUE_BITS_DEF,
	parameter int SNAP_BITS  = svarr_pkg::SNAP_BITS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	output logic                               busy,
	input  logic [svarr_pkg::OPCODE_W-1:0]     opcode,
	input  logic [svarr_pkg::INDEX_W-1:0]      elem_index,
	input  logic [svarr_pkg::VALUE_W-1:0]      write_value,
	input  logic [svarr_pkg::SNAP_W-1:0]       query_snap,
	output logic                               done,
	output logic [svarr_pkg::VALUE_W-1:0]      read_value,
	output logic [svarr_pkg::SNAP_W-1:0]       snap_number,
	output logic [svarr_pkg::STATUS_W-1:0]     status
);

	localparam int AW  = (LENGTH > 1) ? $clog2(LENGTH) : 1;
	localparam int EW  = SNAP_BITS + 1;
	localparam int ENW = EW + VALUE_BITS;
	localparam int RW  = HISTORY * ENW;
	localparam int FW  = $clog2(HISTORY + 1);
	localparam int CW  = (EW > svarr_pkg::SNAP_W) ? EW : svarr_pkg::SNAP_W;

	logic                          accept;
	logic                          clearing_q;
	logic [AW-1:0]                 clr_addr_q;
	logic [EW-1:0]                 snaps_taken_q;

	logic                          valid_s1;
	svarr_pkg::op_t                op_s1;
	logic                          in_range_s1;
	logic [AW-1:0]                 addr_s1;
	logic [VALUE_BITS-1:0]         value_s1;
	logic [svarr_pkg::SNAP_W-1:0]  query_s1;

	logic [RW-1:0]                 row_rd;
	logic [FW-1:0]                 fill_rd;
	logic [RW-1:0]                 new_row;
	logic [FW-1:0]                 new_fill;
	logic [VALUE_BITS-1:0]         get_value;
	svarr_pkg::row_flags_t         flags;

	logic                          hist_we;
	logic                          fill_we;
	logic [AW-1:0]                 fill_waddr;
	logic [FW-1:0]                 fill_wdata;
	logic                          exhausted;
	logic                          not_taken;

	logic                          done_q;
	logic [svarr_pkg::VALUE_W-1:0] read_value_q;
	logic [svarr_pkg::SNAP_W-1:0]  snap_number_q;
	svarr_pkg::status_t            status_q;
	logic [svarr_pkg::VALUE_W-1:0] rd_next;
	logic [svarr_pkg::SNAP_W-1:0]  sn_next;
	svarr_pkg::status_t            st_next;

	assign busy   = clearing_q | valid_s1;
	assign accept = start & ~busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clearing_q <= 1'b1;
			clr_addr_q <= '0;
		end else if (clearing_q) begin
			clr_addr_q <= clr_addr_q + AW'(1);
			if (clr_addr_q == AW'(LENGTH - 1)) begin
				clearing_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1       <= svarr_pkg::op_t'(opcode);
			in_range_s1 <= 32'(elem_index) < LENGTH;
			addr_s1     <= AW'(elem_index);
			value_s1    <= VALUE_BITS'(write_value);
			query_s1    <= query_snap;
		end
	end

	svarr_ram #(.W(RW), .D(LENGTH)) u_hist_ram (
		.clk   (clk),
		.we    (hist_we),
		.waddr (addr_s1),
		.wdata (new_row),
		.re    (accept),
		.raddr (AW'(elem_index)),
		.rdata (row_rd)
	);

	svarr_ram #(.W(FW), .D(LENGTH)) u_fill_ram (
		.clk   (clk),
		.we    (fill_we),
		.waddr (fill_waddr),
		.wdata (fill_wdata),
		.re    (accept),
		.raddr (AW'(elem_index)),
		.rdata (fill_rd)
	);

	svarr_row_unit #(
		.HISTORY    (HISTORY),
		.VALUE_BITS (VALUE_BITS),
		.SNAP_BITS  (SNAP_BITS)
	) u_row_unit (
		.row       (row_rd),
		.fill      (fill_rd),
		.epoch     (snaps_taken_q),
		.value     (value_s1),
		.query     (query_s1),
		.new_row   (new_row),
		.new_fill  (new_fill),
		.get_value (get_value),
		.flags     (flags)
	);

	assign hist_we    = valid_s1 && (op_s1 == svarr_pkg::OP_SET) && in_range_s1 && flags.wr_en;
	assign fill_we    = clearing_q | hist_we;
	assign fill_waddr = clearing_q ? clr_addr_q : addr_s1;
	assign fill_wdata = clearing_q ? '0 : new_fill;
	assign exhausted  = snaps_taken_q[SNAP_BITS];
	assign not_taken  = CW'(query_s1) >= CW'(snaps_taken_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			snaps_taken_q <= '0;
		end else if (valid_s1 && (op_s1 == svarr_pkg::OP_SNAP) && !exhausted) begin
			snaps_taken_q <= snaps_taken_q + EW'(1);
		end
	end

	always_comb begin
		rd_next = '0;
		sn_next = '0;
		st_next = svarr_pkg::ST_OK;
		case (op_s1)
			svarr_pkg::OP_SET: begin
				if (in_range_s1 && flags.full) begin
					st_next = svarr_pkg::ST_FULL;
				end
			end
			svarr_pkg::OP_SNAP: begin
				if (exhausted) begin
					st_next = svarr_pkg::ST_EXHAUSTED;
				end else begin
					sn_next = svarr_pkg::SNAP_W'(snaps_taken_q);
				end
			end
			svarr_pkg::OP_GET: begin
				if (not_taken) begin
					st_next = svarr_pkg::ST_NOT_TAKEN;
				end else if (in_range_s1) begin
					rd_next = svarr_pkg::VALUE_W'(get_value);
				end
			end
			default: begin
				st_next = svarr_pkg::ST_OK;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			read_value_q  <= rd_next;
			snap_number_q <= sn_next;
			status_q      <= st_next;
		end
	end

	assign done        = done_q;
	assign read_value  = read_value_q;
	assign snap_number = snap_number_q;
	assign status      = status_q;

	a_done_follows_item: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> $past(valid_s1))
		else $error("Result strobe without an item in the row stage.");

	a_no_item_while_clearing: assert property (@(posedge clk) disable iff (!arst_n)
		clearing_q |-> !valid_s1 && !hist_we)
		else $error("Item processed during the fill clearing pass.");

	a_counter_bound: assert property (@(posedge clk) disable iff (!arst_n)
		!snaps_taken_q[SNAP_BITS] || (snaps_taken_q[SNAP_BITS-1:0] == '0))
		else $error("Snapshot counter passed its limit.");

	a_exhausted_only_snap: assert property (@(posedge clk) disable iff (!arst_n)
		done_q && (status_q == svarr_pkg::ST_EXHAUSTED) |-> $past(op_s1 == svarr_pkg::OP_SNAP))
		else $error("Exhausted status on an item that is not a snap.");

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_we |-> 32'(fill_wdata) <= HISTORY)
		else $error("Fill count written beyond the history depth.");

endmodule

/* test/snapshot_versioned_array_test.sv */
// Testbench of the snapshot versioned array: directed and random items, checked against fixed or predicted replies.
module snapshot_versioned_array_test;
	timeunit 1ns;
	timeprecision 1ps;

	import svarr_pkg::*;

	localparam int LENGTH = LENGTH_DEF;
	localparam int HISTORY = HISTORY_DEF;
	localparam int EPOCH_W = SNAP_W + 1;
	localparam int SNAP_LIMIT = 1 << SNAP_BITS_DEF;
	localparam int CYCLE_LIMIT = 1000000;
	localparam int RANDOM_ITEMS = 180;
	localparam int HOT_COUNT = 6;
	localparam int DIRECTED_COUNT = 23;

	typedef struct packed {
		op_t op;
		logic [INDEX_W-1:0] index;
		logic [VALUE_W-1:0] value;
		logic [SNAP_W-1:0] query;
	} command_t;

	typedef struct packed {
		logic [VALUE_W-1:0] read_value;
		logic [SNAP_W-1:0] snap_number;
		status_t status;
	} reply_t;

	typedef struct packed {
		op_t op;
		logic [INDEX_W-1:0] index;
		logic [VALUE_W-1:0] value;
		logic [SNAP_W-1:0] query;
		logic fixed;
		logic [VALUE_W-1:0] read_value;
		logic [SNAP_W-1:0] snap_number;
		status_t status;
	} directed_row_t;

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	logic [OPCODE_W-1:0] opcode;
	logic [INDEX_W-1:0] elem_index;
	logic [VALUE_W-1:0] write_value;
	logic [SNAP_W-1:0] query_snap;
	logic done;
	logic [VALUE_W-1:0] read_value;
	logic [SNAP_W-1:0] snap_number;
	logic [STATUS_W-1:0] status;

	logic [EPOCH_W-1:0] epoch_log [LENGTH][HISTORY];
	logic [VALUE_W-1:0] value_log [LENGTH][HISTORY];
	int entry_count [LENGTH];
	int snaps_closed;
	reply_t pending_replies [$];
	int error_count;
	int cycle_count;
	logic [INDEX_W-1:0] hot_index [HOT_COUNT];
	directed_row_t directed_rows [DIRECTED_COUNT];
	int idle_percent [4] = '{0, 65, 0, 31};

	snapshot_versioned_array DUT (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.opcode(opcode),
		.elem_index(elem_index),
		.write_value(write_value),
		.query_snap(query_snap),
		.done(done),
		.read_value(read_value),
		.snap_number(snap_number),
		.status(status)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic reply_t apply_command(input command_t cmd);
		reply_t r;
		int fill;
		bit found;
		r = '{read_value: '0, snap_number: '0, status: ST_OK};
		fill = entry_count[cmd.index];
		case (cmd.op)
			OP_SET: begin
				if (fill > 0 && epoch_log[cmd.index][fill-1] == snaps_closed) begin
					value_log[cmd.index][fill-1] = cmd.value;
				end else if (fill >= HISTORY) begin
					r.status = ST_FULL;
				end else begin
					value_log[cmd.index][fill] = cmd.value;
					epoch_log[cmd.index][fill] = EPOCH_W'(snaps_closed);
					entry_count[cmd.index] = fill + 1;
				end
			end
			OP_SNAP: begin
				if (snaps_closed >= SNAP_LIMIT) begin
					r.status = ST_EXHAUSTED;
				end else begin
					r.snap_number = SNAP_W'(snaps_closed);
					snaps_closed++;
				end
			end
			OP_GET: begin
				if (int'(cmd.query) >= snaps_closed) begin
					r.status = ST_NOT_TAKEN;
				end else begin
					found = 1'b0;
					for (int k = fill - 1; k >= 0; k--) begin
						if (!found && epoch_log[cmd.index][k] <= cmd.query) begin
							r.read_value = value_log[cmd.index][k];
							found = 1'b1;
						end
					end
				end
			end
			default: ;
		endcase
		return r;
	endfunction

	function automatic command_t random_command();
		command_t cmd;
		int roll;
		roll = $urandom_range(99);
		if (roll < 35) cmd.op = OP_SET;
		else if (roll < 55) cmd.op = OP_SNAP;
		else if (roll < 92) cmd.op = OP_GET;
		else cmd.op = OP_NOP;
		roll = $urandom_range(9);
		if (roll < 7) cmd.index = hot_index[$urandom_range(HOT_COUNT - 1)];
		else if (roll == 7) cmd.index = INDEX_W'($urandom_range(1) ? LENGTH - 1 : 0);
		else cmd.index = INDEX_W'($urandom_range(LENGTH - 1));
		roll = $urandom_range(9);
		if (roll == 0) cmd.value = '0;
		else if (roll == 1) cmd.value = '1;
		else cmd.value = VALUE_W'($urandom());
		roll = $urandom_range(7);
		if (snaps_closed > 0 && roll < 5) cmd.query = SNAP_W'($urandom_range(snaps_closed - 1));
		else if (roll == 5 && snaps_closed < SNAP_LIMIT) cmd.query = SNAP_W'(snaps_closed);
		else cmd.query = SNAP_W'($urandom_range(16'hFFFF));
		return cmd;
	endfunction

	task automatic issue(input command_t cmd, input bit fixed, input reply_t fixed_reply,
			input int idle_pct);
		int gap;
		reply_t predicted;
		gap = 0;
		while (idle_pct > 0 && $urandom_range(99) < idle_pct && gap < 20) gap++;
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		opcode <= cmd.op;
		elem_index <= cmd.index;
		write_value <= cmd.value;
		query_snap <= cmd.query;
		do @(posedge clk); while (busy !== 1'b0);
		predicted = apply_command(cmd);
		pending_replies.insert(pending_replies.size(), fixed ? fixed_reply : predicted);
	endtask

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	always @(posedge clk) begin : check_results
		reply_t want;
		if (arst_n && done === 1'b1) begin
			if (pending_replies.size() == 0) begin
				$error("unexpected result: read_value %h, snap_number %0d, status %0d",
					read_value, snap_number, status);
				error_count++;
			end else begin
				want = pending_replies.pop_front();
				if (read_value !== want.read_value) begin
					$error("read_value: expected %h, got %h", want.read_value, read_value);
					error_count++;
				end
				if (snap_number !== want.snap_number) begin
					$error("snap_number: expected %0d, got %0d", want.snap_number, snap_number);
					error_count++;
				end
				if (status !== want.status) begin
					$error("status: expected %0d, got %0d", want.status, status);
					error_count++;
				end
			end
		end
	end

	initial begin
		command_t cmd;
		reply_t no_reply;
		arst_n = 1'b0;
		start = 1'b0;
		opcode = OP_NOP;
		elem_index = '0;
		write_value = '0;
		query_snap = '0;
		error_count = 0;
		cycle_count = 0;
		snaps_closed = 0;
		no_reply = '{read_value: '0, snap_number: '0, status: ST_OK};
		for (int i = 0; i < LENGTH; i++) entry_count[i] = 0;
		for (int i = 0; i < HOT_COUNT; i++) hot_index[i] = INDEX_W'($urandom_range(LENGTH - 1));
		directed_rows = '{
			'{OP_GET,  10'd0,    30'h0,        16'h0,    1'b1, 30'h0,        16'd0, ST_NOT_TAKEN},
			'{OP_NOP,  10'd1023, 30'h3FFFFFFF, 16'hFFFF, 1'b1, 30'h0,        16'd0, ST_OK},
			'{OP_SET,  10'd0,    30'h3FFFFFFF, 16'h0,    1'b1, 30'h0,        16'd0, ST_OK},
			'{OP_SET,  10'd1023, 30'h0,        16'hFFFF, 1'b1, 30'h0,        16'd0, ST_OK},
			'{OP_SET,  10'd512,  30'h2AAAAAAA, 16'h0,    1'b1, 30'h0,        16'd0, ST_OK},
			'{OP_SNAP, 10'd0,    30'h0,        16'h0,    1'b1, 30'h0,        16'd0, ST_OK},
			'{OP_GET,  10'd0,    30'h0,        16'h0,    1'b1, 30'h3FFFFFFF, 16'd0, ST_OK},
			'{OP_GET,  10'd1023, 30'h0,        16'h0,    1'b1, 30'h0,        16'd0, ST_OK},
			'{OP_GET,  10'd5,    30'h0,        16'h0,    1'b1, 30'h0,        16'd0, ST_OK},
			'{OP_GET,  10'd0,    30'h0,        16'hFFFF, 1'b1, 30'h0,        16'd0, ST_NOT_TAKEN},
			'{OP_GET,  10'd0,    30'h0,        16'h1,    1'b1, 30'h0,        16'd0, ST_NOT_TAKEN},
			'{OP_SET,  10'd0,    30'h15555555, 16'h0,    1'b0, 30'h0,        16'd0, ST_OK},
			'{OP_SET,  10'd0,    30'h2AAAAAAA, 16'h0,    1'b0, 30'h0,        16'd0, ST_OK},
			'{OP_SET,  10'd512,  30'h15555555, 16'h0,    1'b0, 30'h0,        16'd0, ST_OK},
			'{OP_SNAP, 10'd0,    30'h0,        16'hFFFF, 1'b1, 30'h0,        16'd1, ST_OK},
			'{OP_GET,  10'd0,    30'h0,        16'h1,    1'b0, 30'h0,        16'd0, ST_OK},
			'{OP_GET,  10'd0,    30'h0,        16'h0,    1'b0, 30'h0,        16'd0, ST_OK},
			'{OP_GET,  10'd512,  30'h0,        16'h1,    1'b0, 30'h0,        16'd0, ST_OK},
			'{OP_NOP,  10'd0,    30'h0,        16'h0,    1'b1, 30'h0,        16'd0, ST_OK},
			'{OP_SNAP, 10'd0,    30'h0,        16'h0,    1'b1, 30'h0,        16'd2, ST_OK},
			'{OP_GET,  10'd1023, 30'h0,        16'h2,    1'b0, 30'h0,        16'd0, ST_OK},
			'{OP_SET,  10'd1023, 30'h3FFFFFFF, 16'h0,    1'b0, 30'h0,        16'd0, ST_OK},
			'{OP_GET,  10'd1023, 30'h0,        16'h2,    1'b0, 30'h0,        16'd0, ST_OK}
		};
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		foreach (directed_rows[i]) begin
			cmd = '{op: directed_rows[i].op, index: directed_rows[i].index,
				value: directed_rows[i].value, query: directed_rows[i].query};
			issue(cmd, directed_rows[i].fixed, '{read_value: directed_rows[i].read_value,
				snap_number: directed_rows[i].snap_number, status: directed_rows[i].status}, 0);
		end

		// Fill one history completely, overwrite its newest entry, then overflow it.
		for (int k = 0; k < HISTORY; k++) begin
			issue('{op: OP_SNAP, index: '0, value: '0, query: '0}, 1'b0, no_reply, 0);
			issue('{op: OP_SET, index: 10'd7, value: VALUE_W'($urandom()), query: '0}, 1'b0,
				no_reply, 0);
		end
		issue('{op: OP_SET, index: 10'd7, value: VALUE_W'($urandom()), query: '0}, 1'b0,
			no_reply, 0);
		issue('{op: OP_SNAP, index: '0, value: '0, query: '0}, 1'b0, no_reply, 0);
		issue('{op: OP_SET, index: 10'd7, value: VALUE_W'($urandom()), query: '0}, 1'b0,
			no_reply, 0);
		for (int k = 0; k < 6; k++) begin
			cmd = '{op: OP_GET, index: 10'd7, value: '0,
				query: SNAP_W'($urandom_range(snaps_closed - 1))};
			issue(cmd, 1'b0, no_reply, 0);
		end

		foreach (idle_percent[p]) begin
			for (int n = 0; n < RANDOM_ITEMS; n++) begin
				issue(random_command(), 1'b0, no_reply, idle_percent[p]);
			end
		end

		for (int k = 0; k < 3; k++) begin
			issue('{op: OP_SNAP, index: '0, value: '0, query: '0}, 1'b0, no_reply, 0);
		end
		issue('{op: OP_GET, index: hot_index[0], value: '0, query: 16'hFFFF}, 1'b0,
			no_reply, 0);
		for (int k = 0; k < 30; k++) begin
			issue(random_command(), 1'b0, no_reply, 31);
		end
		start <= 1'b0;

		while (pending_replies.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		if (error_count == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule

/* sim.f */
rtl/svarr_pkg.sv
rtl/svarr_ram.sv
rtl/svarr_row_unit.sv
rtl/snapshot_versioned_array.sv
test/snapshot_versioned_array_test.sv
